>>> hw/rtl/spq_pkg.sv
// shared types, constants and codes for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  // default number of stored entries
  localparam int unsigned DEPTH_DEF = 8;

  // widths of the item fields
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // flags from the shared compare unit
  typedef struct packed {
    logic ge;  // probe value greater than or equal to stored entry (signed)
    logic eq;  // probe value equal to stored entry
  } cmp_res_t;

endpackage

>>> hw/rtl/spq_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/spq_cmp.sv
// shared compare unit: probe value against one stored entry
`timescale 1ns / 1ps
module spq_cmp (
  input  logic signed [spq_pkg::VALUE_W-1:0] probe,
  input  logic signed [spq_pkg::VALUE_W-1:0] entry,
  output spq_pkg::cmp_res_t                  res
);

  // one signed (two's complement) compare and one equality test
  always_comb begin
    res.ge = (probe >= entry);
    res.eq = (probe == entry);
  end

endmodule

>>> hw/rtl/sorted_priority_queue_unit.sv
// top level of the sorted priority queue: sequencer, entry store and result register
`timescale 1ns / 1ps
// Holds up to DEPTH signed 32-bit values in descending order in a small ram and
// walks it with one shared compare unit. An insert item (in_tuser 0) places its
// value ahead of the first entry less than or equal to it and moves later entries
// back in the same pass; a delete item (in_tuser 1) removes the first equal entry
// and moves later entries forward. Each item gives one result item: status, count
// after the operation (low four bits) and the head value, zero when empty. The ram
// has one read and one write port with a registered read, so each stored entry is
// read in S_RD and then compared and written in S_EX, and both operations always
// walk every stored entry; overflow and empty cases go straight to S_DONE. in_tready
// is high only while no item is being worked on; a finished result waits in the
// output register until taken.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] value
  input  logic                                in_tuser,   // [0] func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]     out_tdata   // [1:0] status, [5:2] count,
                                                          // [37:6] head_value, [39:38] zero
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // sequencer state codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic                          func_r, func_nxt;
  logic [spq_pkg::VALUE_W-1:0]   value_r, value_nxt;
  logic [spq_pkg::VALUE_W-1:0]   carry_r, carry_nxt;
  logic                          placed_r, placed_nxt;
  logic                          found_r, found_nxt;
  logic [spq_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [spq_pkg::VALUE_W-1:0]   head_r, head_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [spq_pkg::VALUE_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [spq_pkg::VALUE_W-1:0]   ram_rdata;
  spq_pkg::cmp_res_t             cmp_res;
  logic [spq_pkg::VALUE_W-1:0]   head_out;

  // entry store
  spq_ram #(
    .WIDTH (spq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare unit
  spq_cmp u_cmp (
    .probe (value_r),
    .entry (ram_rdata),
    .res   (cmp_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign ram_raddr  = k_r[IDX_W-1:0];
  assign head_out   = (count_r == '0) ? '0 : head_r;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    func_nxt      = func_r;
    value_nxt     = value_r;
    carry_nxt     = carry_r;
    placed_nxt    = placed_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r[IDX_W-1:0];
    ram_wdata     = carry_r;

    // result register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tuser;
          value_nxt  = in_tdata[spq_pkg::VALUE_W-1:0];
          carry_nxt  = in_tdata[spq_pkg::VALUE_W-1:0];
          k_nxt      = '0;
          placed_nxt = 1'b0;
          found_nxt  = 1'b0;
          status_nxt = spq_pkg::ST_OK;
          state_nxt  = S_RD;
          if (in_tuser == spq_pkg::FUNC_INSERT && count_r == CNT_FULL) begin
            status_nxt = spq_pkg::ST_OVERFLOW;
            state_nxt  = S_DONE;
          end else if (in_tuser == spq_pkg::FUNC_DELETE && count_r == '0) begin
            status_nxt = spq_pkg::ST_EMPTY;
            state_nxt  = S_DONE;
          end
        end
      end

      S_RD: begin
        // insert past the last entry: write the carried value at the tail
        if (func_r == spq_pkg::FUNC_INSERT && k_r == count_r) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_ONE;
          state_nxt = S_DONE;
          if (k_r == '0) begin
            head_nxt = carry_r;
          end
        end else begin
          state_nxt = S_EX;
        end
      end

      S_EX: begin
        if (func_r == spq_pkg::FUNC_INSERT) begin
          // once placed, every later entry moves back by one
          if (placed_r || cmp_res.ge) begin
            ram_we     = 1'b1;
            carry_nxt  = ram_rdata;
            placed_nxt = 1'b1;
            if (k_r == '0) begin
              head_nxt = carry_r;
            end
          end
          k_nxt     = k_r + CNT_ONE;
          state_nxt = S_RD;
        end else begin
          // after the match, every later entry moves forward by one
          if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(k_r - CNT_ONE);
            ram_wdata = ram_rdata;
            if (k_r == CNT_ONE) begin
              head_nxt = ram_rdata;
            end
          end else if (cmp_res.eq) begin
            found_nxt = 1'b1;
          end
          k_nxt = k_r + CNT_ONE;
          if (k_r + CNT_ONE == count_r) begin
            if (found_r || cmp_res.eq) begin
              count_nxt = count_r - CNT_ONE;
            end else begin
              status_nxt = spq_pkg::ST_NOT_FOUND;
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_DONE: begin
        // load the result once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, head_out, spq_pkg::COUNT_W'(count_r), status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    func_r     <= func_nxt;
    value_r    <= value_nxt;
    carry_r    <= carry_nxt;
    placed_r   <= placed_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    head_r     <= head_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench for the sorted priority queue: directed table, random traffic, self-checking predictor
`timescale 1ns / 1ps
module tb_top;

  localparam int QUEUE_DEPTH  = spq_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE_WAIT  = 40;
  localparam int RANDOM_ITEMS = 135;

  // one result item, unpacked from out_tdata
  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::COUNT_W-1:0]  count;
    logic [spq_pkg::VALUE_W-1:0]  head_value;
  } queue_result_t;

  // one row of the directed table; res only used where typed is set
  typedef struct packed {
    logic          func;
    logic [31:0]   value;
    logic          typed;
    queue_result_t res;
  } queue_op_row_t;

  localparam int NUM_DIRECTED = 23;
  localparam queue_op_row_t DIRECTED_OPS [NUM_DIRECTED] = '{
    '{spq_pkg::FUNC_DELETE, 32'h0000_0000, 1'b1, '{spq_pkg::ST_EMPTY, 4'd0, 32'h0000_0000}},
    '{spq_pkg::FUNC_INSERT, 32'h7fff_ffff, 1'b1, '{spq_pkg::ST_OK, 4'd1, 32'h7fff_ffff}},
    '{spq_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, '{spq_pkg::ST_OK, 4'd2, 32'h7fff_ffff}},
    '{spq_pkg::FUNC_DELETE, 32'h0000_0000, 1'b1, '{spq_pkg::ST_NOT_FOUND, 4'd2, 32'h7fff_ffff}},
    '{spq_pkg::FUNC_DELETE, 32'h7fff_ffff, 1'b1, '{spq_pkg::ST_OK, 4'd1, 32'h8000_0000}},
    '{spq_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'hffff_ffff, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'h0000_0005, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'h0000_0005, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'h8000_0001, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'h7fff_fffe, 1'b0, '0},
    '{spq_pkg::FUNC_INSERT, 32'h0000_0001, 1'b1, '{spq_pkg::ST_OVERFLOW, 4'd8, 32'h7fff_fffe}},
    '{spq_pkg::FUNC_DELETE, 32'h0000_0005, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h8000_0000, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h7fff_fffe, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h0001_2345, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'hffff_ffff, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h0000_0005, 1'b0, '0},
    '{spq_pkg::FUNC_DELETE, 32'h8000_0001, 1'b1, '{spq_pkg::ST_OK, 4'd0, 32'h0000_0000}},
    '{spq_pkg::FUNC_DELETE, 32'h8000_0000, 1'b1, '{spq_pkg::ST_EMPTY, 4'd0, 32'h0000_0000}}
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [spq_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata;

  // predictor state: entries in descending order and fill level
  logic [31:0] pq_entries [QUEUE_DEPTH];
  int          pq_fill = 0;

  queue_result_t pending_results [$];
  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  sorted_priority_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tuser   (in_tuser),   // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // [1:0] status, [5:2] count, [37:6] head_value
  );

  // clock
  always #5 clk = ~clk;

  // time limit
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // apply one operation to the predictor and return the result it yields
  function automatic queue_result_t predict_queue_op(input logic op, input logic [31:0] v);
    queue_result_t r;
    int            pos;
    int            k;
    logic          found;
    found = 1'b0;
    pos   = pq_fill;
    if (op == spq_pkg::FUNC_INSERT) begin
      if (pq_fill >= QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // new value goes ahead of the first entry less than or equal to it
        for (k = 0; k < pq_fill; k++) begin
          if (!found && $signed(v) >= $signed(pq_entries[k])) begin
            pos   = k;
            found = 1'b1;
          end
        end
        for (k = pq_fill; k > pos; k--) pq_entries[k] = pq_entries[k-1];
        pq_entries[pos] = v;
        pq_fill++;
        r.status = spq_pkg::ST_OK;
      end
    end else if (pq_fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      // remove the first equal entry and close the gap
      for (k = 0; k < pq_fill; k++) begin
        if (!found && pq_entries[k] == v) begin
          pos   = k;
          found = 1'b1;
        end
      end
      if (found) begin
        for (k = pos; k + 1 < pq_fill; k++) pq_entries[k] = pq_entries[k+1];
        pq_fill--;
        r.status = spq_pkg::ST_OK;
      end else begin
        r.status = spq_pkg::ST_NOT_FOUND;
      end
    end
    r.count      = 4'(pq_fill);
    r.head_value = (pq_fill != 0) ? pq_entries[0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // offer one item, hold it until accepted, then record what should come back
  task automatic send_queue_op(input logic op, input logic [31:0] v, input logic typed,
                               input queue_result_t typed_res);
    queue_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    predicted = predict_queue_op(op, v);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // random operation; deletes are biased towards values already stored
  task automatic send_random_op(input int insert_pct);
    logic        op;
    logic [31:0] v;
    int          pick;
    int          offset;
    op     = ($urandom_range(99) < insert_pct) ? spq_pkg::FUNC_INSERT : spq_pkg::FUNC_DELETE;
    pick   = $urandom_range(9);
    offset = $urandom_range(8);
    if (op == spq_pkg::FUNC_DELETE && pq_fill != 0 && pick < 6) begin
      v = pq_entries[$urandom_range(pq_fill - 1)];
    end else if (pick < 3) begin
      v = offset - 4;
    end else if (pick == 3) begin
      case (offset % 4)
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'hffff_ffff;
        default: v = 32'h0000_0000;
      endcase
    end else begin
      v = $urandom();
    end
    send_queue_op(op, v, 1'b0, '0);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_tready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
        if (out_tdata[5:2] !== want.count)
          report_mismatch("count", 32'(out_tdata[5:2]), 32'(want.count));
        if (out_tdata[37:6] !== want.head_value)
          report_mismatch("head_value", out_tdata[37:6], want.head_value);
      end
    end
  end

  // stimulus
  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 52;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_queue_op(DIRECTED_OPS[i].func, DIRECTED_OPS[i].value, DIRECTED_OPS[i].typed,
                    DIRECTED_OPS[i].res);
    end
    in_tvalid <= 1'b0;
    wait_for_drain();

    // random phases: sender light / receiver heavy, swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 7 : 0;
      if (phase == 0) holds_asked <= holds_asked + 1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        // long receiver hold-off while items keep coming
        if (phase == 2 && i == 60) holds_asked <= holds_asked + 1;
        // alternate between filling and emptying runs
        send_random_op(((i / 20) % 2 == 0) ? 75 : 30);
      end
      in_tvalid <= 1'b0;
      wait_for_drain();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
